// ----- src/swrl_pkg.sv -----
// Shared types and constants for the sliding-window rate limiter.
// Used by every module of the block; depends on nothing else.
package swrl_pkg;

  localparam int unsigned SWRL_LOG_DEPTH = 64;
  localparam int unsigned STAMP_W        = 32;
  localparam int unsigned LIMIT_W        = 7;
  localparam int unsigned COUNT_OUT_W    = 7;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic [STAMP_W-1:0] CLEANUP_GAP_MS = 32'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 7'd60;
  localparam logic [STAMP_W-1:0] WINDOW_RESET   = 32'd60000;

  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS     = 1'b1;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_RECORD = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [STAMP_W-1:0] now_ms;
  } swrl_in_t;

  typedef struct packed {
    logic                   allowed;
    logic [STAMP_W-1:0]     wait_ms;
    logic [COUNT_OUT_W-1:0] active_count;
    logic                   recorded;
  } swrl_out_t;

  // Operands of the shared time-difference unit.
  typedef struct packed {
    logic [STAMP_W-1:0] now_ms;
    logic [STAMP_W-1:0] stamp_ms;
    logic [STAMP_W-1:0] bound_ms;
  } diff_req_t;

  typedef struct packed {
    logic               in_window;
    logic [STAMP_W-1:0] remain_ms;
  } diff_rsp_t;

endpackage

// ----- src/swrl_log_mem.sv -----
// Timestamp log storage: one write port and one registered read port.
// Depends on swrl_pkg for the stamp width.
module swrl_log_mem
  import swrl_pkg::*;
#(
  parameter int unsigned DEPTH = SWRL_LOG_DEPTH,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [STAMP_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [STAMP_W-1:0] rdata
);

  logic [STAMP_W-1:0] mem [DEPTH];
  logic [STAMP_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/swrl_diff_unit.sv -----
// Shared modulo-2^32 time-difference unit: elapsed time, window test and remaining time.
// Depends on swrl_pkg for the operand and result structs.
module swrl_diff_unit
  import swrl_pkg::*;
(
  input  diff_req_t req,
  output diff_rsp_t rsp
);

  logic [STAMP_W-1:0] elapsed;

  assign elapsed       = req.now_ms - req.stamp_ms;
  assign rsp.in_window = (elapsed < req.bound_ms);
  assign rsp.remain_ms = req.bound_ms - elapsed;

endmodule

// ----- src/sliding_window_rate_limiter_top.sv -----
// Sliding-window log rate limiter, top level with sequencer and configuration registers.
// An accepted request passes through an optional cleanup pass over the logged entries, then the
// record, read and done states before the result strobe; busy is high until the sequencer is idle.
// The cleanup pass reads one log entry per cycle through the single memory read port.
// Reset (synchronous, rst_n low) empties the log, zeroes the cleanup time and loads the
// default limit and window. Results are strobed for one cycle; the receiver cannot stall.
module sliding_window_rate_limiter_top
  import swrl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = SWRL_LOG_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  swrl_in_t             in_data,
  output logic                 out_valid,
  output swrl_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [STAMP_W-1:0]   cfg_wdata
);

  localparam int unsigned AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLEAN  = 5'b00010,
    S_RECORD = 5'b00100,
    S_READ0  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   kept_r, kept_nxt;
  logic               pend_r, pend_nxt;
  logic [STAMP_W-1:0] last_clean_r, last_clean_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [STAMP_W-1:0] window_r;
  logic               cmd_r, cmd_nxt;
  logic [STAMP_W-1:0] now_r, now_nxt;
  logic               rec_r, rec_nxt;
  logic               out_valid_r, out_valid_nxt;
  swrl_out_t          out_data_r, out_data_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [STAMP_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [STAMP_W-1:0] mem_rdata;

  diff_req_t          dreq;
  diff_rsp_t          drsp;

  logic [LIM_W-1:0]   lim_eff;
  logic [LIM_W-1:0]   count_ext;
  logic               accept;

  swrl_log_mem #(
    .DEPTH (LOG_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  swrl_diff_unit u_diff (
    .req (dreq),
    .rsp (drsp)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign lim_eff   = (LIM_W'(limit_r) > LIM_W'(LOG_DEPTH)) ? LIM_W'(LOG_DEPTH)
                                                           : LIM_W'(limit_r);
  assign count_ext = LIM_W'(count_r);

  // The difference unit serves the cleanup-gap test on accept and the window tests later.
  always_comb begin
    if (state_r == S_IDLE) begin
      dreq.now_ms   = in_data.now_ms;
      dreq.stamp_ms = last_clean_r;
      dreq.bound_ms = CLEANUP_GAP_MS;
    end else begin
      dreq.now_ms   = now_r;
      dreq.stamp_ms = mem_rdata;
      dreq.bound_ms = window_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    kept_nxt       = kept_r;
    pend_nxt       = pend_r;
    last_clean_nxt = last_clean_r;
    cmd_nxt        = cmd_r;
    now_nxt        = now_r;
    rec_nxt        = rec_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = kept_r[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = rd_idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_data.cmd;
          now_nxt    = in_data.now_ms;
          rec_nxt    = 1'b0;
          rd_idx_nxt = '0;
          kept_nxt   = '0;
          pend_nxt   = 1'b0;
          if (!drsp.in_window) begin
            last_clean_nxt = in_data.now_ms;
            state_nxt      = S_CLEAN;
          end else begin
            state_nxt = S_RECORD;
          end
        end
      end
      S_CLEAN: begin
        // Reads run one entry ahead of the compare; kept entries compact toward the head.
        mem_re   = (rd_idx_r < count_r);
        pend_nxt = mem_re;
        if (mem_re) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (pend_r && drsp.in_window) begin
          mem_we   = 1'b1;
          kept_nxt = kept_r + 1'b1;
        end
        if (!mem_re && !pend_r) begin
          count_nxt = kept_r;
          state_nxt = S_RECORD;
        end
      end
      S_RECORD: begin
        mem_waddr = count_r[AW-1:0];
        mem_wdata = now_r;
        if ((cmd_r == CMD_RECORD) && (count_ext < lim_eff)) begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          rec_nxt   = 1'b1;
        end
        state_nxt = S_READ0;
      end
      S_READ0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.allowed      = (count_ext < lim_eff);
        out_data_nxt.active_count = COUNT_OUT_W'(count_r);
        out_data_nxt.recorded     = rec_r;
        if (!(count_ext < lim_eff) && (count_r != '0) && drsp.in_window) begin
          out_data_nxt.wait_ms = drsp.remain_ms;
        end else begin
          out_data_nxt.wait_ms = '0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rd_idx_r     <= '0;
      kept_r       <= '0;
      pend_r       <= 1'b0;
      last_clean_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      kept_r       <= kept_nxt;
      pend_r       <= pend_nxt;
      last_clean_r <= last_clean_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    now_r      <= now_nxt;
    rec_r      <= rec_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      window_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_REQUEST_LIMIT: limit_r  <= cfg_wdata[LIMIT_W-1:0];
        REG_WINDOW_MS:     window_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LOG_DEPTH))
    else $error("log count exceeds log depth");

  a_record_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.recorded) |-> (count_r != '0))
    else $error("recorded item left the log empty");

  a_wait_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.wait_ms != '0)) |-> !out_data.allowed)
    else $error("nonzero wait reported for an allowed request");

endmodule
